>>> rtl/core/pprd_pkg.sv
`default_nettype none

package pprd_pkg;

    // result kinds
    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_BUTTON = 3'd1;
    localparam logic [2:0] KIND_CSUM   = 3'd2;
    localparam logic [2:0] KIND_ID     = 3'd3;
    localparam logic [2:0] KIND_LEN    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_PACKET_ID     = 2'd0;
    localparam logic [1:0] REG_FILTER_DELAY  = 2'd1;
    localparam logic [1:0] REG_BUTTON_INDEX  = 2'd2;
    localparam logic [1:0] REG_CHECKSUM_SEED = 2'd3;

    // register reset values
    localparam logic [7:0] RST_PACKET_ID     = 8'h00;
    localparam logic [7:0] RST_FILTER_DELAY  = 8'd20;
    localparam logic [4:0] RST_BUTTON_INDEX  = 5'd13;
    localparam logic [7:0] RST_CHECKSUM_SEED = 8'h33;

    localparam logic [7:0] MIN_BUTTON_LEN = 8'd15;
    localparam logic [7:0] MIN_PACKET_LEN = 8'd2;
    localparam logic [1:0] CODE_NEXT      = 2'b01;
    localparam logic [1:0] CODE_RETURN    = 2'b10;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic fetch;      // read next relay byte from the store
        logic send_byte;  // push fetched relay byte to the output
        logic send_csum;  // push recomputed checksum as last byte
    } pprd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a beat this cycle
        logic pkt_good;   // current input beat completes a relayable packet
        logic last_data;  // relay index sits on the last byte before checksum
    } pprd_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/pprd_if.sv
`default_nettype none

interface pprd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       next_pin;
    logic       return_pin;

    modport source (
        output valid, req_type, rx_byte, frame_start, next_pin, return_pin,
        input  ready
    );
    modport sink (
        input  valid, req_type, rx_byte, frame_start, next_pin, return_pin,
        output ready
    );
endinterface

interface pprd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] button_mask;

    modport source (
        output valid, out_kind, out_byte, out_last, button_mask,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_byte, out_last, button_mask,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/pprd_ram.sv
`default_nettype none

module pprd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

>>> rtl/core/pprd_ctrl.sv
`default_nettype none

module pprd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pprd_pkg::pprd_stat_t stat,
    output pprd_pkg::pprd_cmd_t      cmd
);
    import pprd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;
    localparam logic [1:0] S_CSUM  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.accept    = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.pkt_good)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (stat.out_free)
                begin
                    cmd.send_byte = 1'b1;
                    state_next    = stat.last_data ? S_CSUM : S_FETCH;
                end
            end
            S_CSUM:
            begin
                if (stat.out_free)
                begin
                    cmd.send_csum = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_fetch_then_send: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> state_reg == S_SEND)
        else $error("fetch not followed by send");
    a_good_starts_relay: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stat.pkt_good |=> state_reg == S_FETCH)
        else $error("good packet did not start relay");
    a_no_input_in_relay: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input taken during relay");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pprd_dp.sv
`default_nettype none

module pprd_dp #(
    parameter int MAX_PACKET = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pprd_pkg::pprd_cmd_t cmd,
    output pprd_pkg::pprd_stat_t     stat,
    input  wire logic                req_type,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                frame_start,
    input  wire logic                next_pin,
    input  wire logic                return_pin,
    input  wire logic [7:0]          packet_id,
    input  wire logic [7:0]          filter_delay,
    input  wire logic [4:0]          button_index,
    input  wire logic [7:0]          checksum_seed,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               out_kind,
    output logic [7:0]               out_byte,
    output logic                     out_last,
    output logic [1:0]               button_mask
);
    import pprd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PACKET + 1);
    localparam int ADDR_W = $clog2(MAX_PACKET);

    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] packet_length_reg;
    logic [7:0]       running_sum_reg;
    logic             receiving_reg;
    logic [7:0]       id_byte_reg;
    logic [7:0]       next_cnt_reg;
    logic [7:0]       ret_cnt_reg;
    logic [CNT_W-1:0] relay_idx_reg;
    logic [7:0]       relay_sum_reg;
    logic             out_valid_reg;
    logic [2:0]       out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic [1:0]       out_mask_reg;

    logic [7:0]       next_cnt_next;
    logic [7:0]       ret_cnt_next;
    logic [1:0]       mask_now;
    logic [1:0]       mask_tick;
    logic [CNT_W-1:0] cnt_inc;
    logic             is_tick;
    logic             is_start;
    logic             is_body;
    logic             len_bad;
    logic             completes;
    logic [7:0]       id_seen;
    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]       ram_rdata;
    logic             replace;
    logic [7:0]       relay_byte;
    logic             res_load;
    logic [2:0]       res_kind;

    function automatic logic [7:0] debounce(input logic [7:0] cnt, input logic pressed,
                                            input logic [7:0] limit);
        logic [7:0] r;
        if (!pressed)
        begin
            r = 8'd0;
        end
        else if (cnt <= limit && cnt != 8'hFF)
        begin
            r = cnt + 8'd1;
        end
        else
        begin
            r = cnt;
        end
        return r;
    endfunction

    assign next_cnt_next = debounce(next_cnt_reg, !next_pin, filter_delay);
    assign ret_cnt_next  = debounce(ret_cnt_reg, !return_pin, filter_delay);
    assign mask_now  = ((next_cnt_reg > filter_delay) ? CODE_NEXT : 2'b00)
                     | ((ret_cnt_reg > filter_delay) ? CODE_RETURN : 2'b00);
    assign mask_tick = ((next_cnt_next > filter_delay) ? CODE_NEXT : 2'b00)
                     | ((ret_cnt_next > filter_delay) ? CODE_RETURN : 2'b00);

    assign is_tick   = req_type;
    assign is_start  = !req_type && frame_start;
    assign is_body   = !req_type && !frame_start && receiving_reg;
    assign len_bad   = (rx_byte < MIN_PACKET_LEN) || (rx_byte > 8'(MAX_PACKET));
    assign cnt_inc   = byte_count_reg + CNT_W'(1);
    assign completes = is_body && (cnt_inc == packet_length_reg);
    assign id_seen   = (byte_count_reg == CNT_W'(1)) ? rx_byte : id_byte_reg;

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.pkt_good  = completes && (running_sum_reg == rx_byte)
                            && (id_seen == packet_id);
    assign stat.last_data = ({1'b0, relay_idx_reg} + (CNT_W + 1)'(2))
                            == {1'b0, packet_length_reg};

    // packet store write port follows the input beat, read port the relay
    assign ram_we    = cmd.accept && ((is_start && !len_bad) || is_body);
    assign ram_waddr = is_start ? '0 : byte_count_reg[ADDR_W-1:0];

    pprd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PACKET)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (cmd.fetch),
        .raddr (relay_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign replace    = ({1'b0, packet_length_reg} >= (CNT_W + 1)'(MIN_BUTTON_LEN))
                        && (8'(relay_idx_reg) == {3'b000, button_index});
    assign relay_byte = replace ? {6'd0, mask_now} : ram_rdata;

    // single-beat results caused by an input beat
    always_comb
    begin
        res_load = 1'b0;
        res_kind = KIND_BUTTON;
        if (cmd.accept)
        begin
            if (is_tick)
            begin
                res_load = 1'b1;
                res_kind = KIND_BUTTON;
            end
            else if (is_start && len_bad)
            begin
                res_load = 1'b1;
                res_kind = KIND_LEN;
            end
            else if (completes && running_sum_reg != rx_byte)
            begin
                res_load = 1'b1;
                res_kind = KIND_CSUM;
            end
            else if (completes && id_seen != packet_id)
            begin
                res_load = 1'b1;
                res_kind = KIND_ID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            packet_length_reg <= '0;
            running_sum_reg   <= '0;
            receiving_reg     <= 1'b0;
            next_cnt_reg      <= '0;
            ret_cnt_reg       <= '0;
            relay_idx_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (is_tick)
                begin
                    next_cnt_reg <= next_cnt_next;
                    ret_cnt_reg  <= ret_cnt_next;
                end
                else if (is_start)
                begin
                    byte_count_reg    <= len_bad ? '0 : CNT_W'(1);
                    packet_length_reg <= rx_byte[CNT_W-1:0];
                    running_sum_reg   <= checksum_seed + rx_byte;
                    receiving_reg     <= !len_bad;
                end
                else if (is_body)
                begin
                    byte_count_reg <= cnt_inc;
                    if (completes)
                    begin
                        receiving_reg <= 1'b0;
                        relay_idx_reg <= '0;
                    end
                    else
                    begin
                        running_sum_reg <= running_sum_reg + rx_byte;
                    end
                end
            end
            if (cmd.send_byte)
            begin
                relay_idx_reg <= relay_idx_reg + CNT_W'(1);
            end
            if (res_load || cmd.send_byte || cmd.send_csum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_body && byte_count_reg == CNT_W'(1))
        begin
            id_byte_reg <= rx_byte;
        end
        if (cmd.accept && completes)
        begin
            relay_sum_reg <= checksum_seed;
        end
        else if (cmd.send_byte)
        begin
            relay_sum_reg <= relay_sum_reg + relay_byte;
        end
        if (res_load)
        begin
            out_kind_reg <= res_kind;
            out_byte_reg <= 8'd0;
            out_last_reg <= 1'b1;
            out_mask_reg <= (res_kind == KIND_BUTTON) ? mask_tick : 2'b00;
        end
        else if (cmd.send_byte)
        begin
            out_kind_reg <= KIND_BYTE;
            out_byte_reg <= relay_byte;
            out_last_reg <= 1'b0;
            out_mask_reg <= 2'b00;
        end
        else if (cmd.send_csum)
        begin
            out_kind_reg <= KIND_BYTE;
            out_byte_reg <= relay_sum_reg;
            out_last_reg <= 1'b1;
            out_mask_reg <= 2'b00;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_byte    = out_byte_reg;
    assign out_last    = out_last_reg;
    assign button_mask = out_mask_reg;

`ifndef SYNTHESIS
    a_recv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> byte_count_reg < packet_length_reg
                          && byte_count_reg != '0)
        else $error("byte count out of packet range");
    a_csum_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.send_csum |=> out_valid_reg && out_last_reg && out_kind_reg == KIND_BYTE)
        else $error("checksum beat not marked last");
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != KIND_BYTE |-> out_last_reg)
        else $error("single result not marked last");
`endif

endmodule

`default_nettype wire

>>> rtl/core/panel_packet_relay_with_debounce.sv
`default_nettype none

// channel   dir  handshake        payload
// in_ch     in   valid / ready    req_type, rx_byte, frame_start, next_pin, return_pin
// out_ch    out  valid / ready    out_kind, out_byte, out_last, button_mask
// apb       in   psel / penable   paddr, pwdata, pwrite; prdata back, pready tied high
//
// ticks, stray and non-final packet bytes are taken back to back while output is free
// a good packet of length n relays n-1 stored bytes and a new checksum, input held off:
//   the registered store read is fetched in S_FETCH and sent in S_SEND per byte
// bad length, checksum or identifier loads one beat at the accept edge
// reset is asynchronous; the packet store has no clear, it is only read after write
// output stalls hold the relay in place and hold off new input beats

module panel_packet_relay_with_debounce #(
    parameter int MAX_PACKET = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pprd_in_if.sink          in_ch,
    pprd_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import pprd_pkg::*;

    // configuration registers
    logic [7:0] packet_id_reg;
    logic [7:0] filter_delay_reg;
    logic [4:0] button_index_reg;
    logic [7:0] checksum_seed_reg;

    logic       cfg_write;
    logic [1:0] cfg_sel;

    pprd_cmd_t  cmd;
    pprd_stat_t stat;

    // apb: no wait states, write lands at the access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_id_reg     <= RST_PACKET_ID;
            filter_delay_reg  <= RST_FILTER_DELAY;
            button_index_reg  <= RST_BUTTON_INDEX;
            checksum_seed_reg <= RST_CHECKSUM_SEED;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_PACKET_ID:     packet_id_reg     <= pwdata[7:0];
                REG_FILTER_DELAY:  filter_delay_reg  <= pwdata[7:0];
                REG_BUTTON_INDEX:  button_index_reg  <= pwdata[4:0];
                REG_CHECKSUM_SEED: checksum_seed_reg <= pwdata[7:0];
                default:           packet_id_reg     <= packet_id_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_sel)
            REG_PACKET_ID:     prdata = {24'd0, packet_id_reg};
            REG_FILTER_DELAY:  prdata = {24'd0, filter_delay_reg};
            REG_BUTTON_INDEX:  prdata = {27'd0, button_index_reg};
            REG_CHECKSUM_SEED: prdata = {24'd0, checksum_seed_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // sequencer: idle intake, then fetch/send per relay byte, then checksum beat
    pprd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // packet store, sums, debounce counters and the output register
    pprd_dp #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (in_ch.req_type),
        .rx_byte       (in_ch.rx_byte),
        .frame_start   (in_ch.frame_start),
        .next_pin      (in_ch.next_pin),
        .return_pin    (in_ch.return_pin),
        .packet_id     (packet_id_reg),
        .filter_delay  (filter_delay_reg),
        .button_index  (button_index_reg),
        .checksum_seed (checksum_seed_reg),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_kind      (out_ch.out_kind),
        .out_byte      (out_ch.out_byte),
        .out_last      (out_ch.out_last),
        .button_mask   (out_ch.button_mask)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pprd_pkg::*;

    localparam int MAX_PKT         = 32;
    localparam int DRAIN_LIMIT     = 20000;  // cycles allowed for outstanding beats to drain
    localparam int SETTLE_CYCLES   = 8;      // quiet cycles before a register write
    localparam int ITEMS_PER_PHASE = 8;

    // one input beat
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       next_pin;
        logic       return_pin;
    } beat_t;

    // one output beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] mask;
    } result_t;

    // how a generated packet is spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_CSUM,
        FLAW_ID
    } flaw_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pprd_in_if  in_ch ();
    pprd_out_if out_ch ();

    panel_packet_relay_with_debounce uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor state: register copies and the block's own state
    // ---------------------------------------------------------------
    logic [7:0] id_reg    = RST_PACKET_ID;
    logic [7:0] delay_reg = RST_FILTER_DELAY;
    logic [4:0] bidx_reg  = RST_BUTTON_INDEX;
    logic [7:0] seed_reg  = RST_CHECKSUM_SEED;

    logic [7:0] pkt_buf [MAX_PKT];
    int         rx_count  = 0;
    int         pkt_len   = 0;
    logic [7:0] rx_sum    = 8'h00;
    bit         in_packet = 1'b0;
    logic [7:0] next_cnt  = 8'h00;
    logic [7:0] ret_cnt   = 8'h00;

    // output beats predicted but not yet seen, oldest first
    result_t outbound_queue [$];

    // run statistics
    int errors          = 0;
    int beats_sent      = 0;
    int stray_beats     = 0;
    int ticks_sent      = 0;
    int results_seen    = 0;
    int packets_relayed = 0;
    int reject_results  = 0;

    // pacing controls shared by the test tasks and the receiver
    bit tx_steady = 1'b0;  // sender offers beats back to back
    bit rx_steady = 1'b0;  // receiver never stalls on its own
    int rx_hold   = 0;     // cycles the receiver must hold off, counted down below

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // pins lean toward pressed so the debounced mask actually sets
    function automatic logic pin_level();
        return ($urandom_range(99, 0) < 70) ? 1'b0 : 1'b1;
    endfunction

    function automatic logic [7:0] debounce_step(logic [7:0] cnt, logic pressed);
        if (!pressed)
            return 8'h00;
        if (cnt <= delay_reg && cnt != 8'hFF)
            return cnt + 8'h01;
        return cnt;
    endfunction

    function automatic logic [1:0] debounced_mask();
        logic [1:0] m;
        m = 2'b00;
        if (next_cnt > delay_reg)
            m = m | CODE_NEXT;
        if (ret_cnt > delay_reg)
            m = m | CODE_RETURN;
        return m;
    endfunction

    function automatic void owe_result(logic [2:0] kind, logic [7:0] data, logic last,
                                       logic [1:0] mask);
        result_t r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        r.mask = mask;
        outbound_queue.push_back(r);
    endfunction

    // advances the predicted block by one accepted input beat
    task automatic predict_relay(input beat_t b);
        logic [7:0] sum;
        int         i;
        if (b.req_type)
        begin
            // timer tick: both buttons debounced, one report beat
            next_cnt = debounce_step(next_cnt, !b.next_pin);
            ret_cnt  = debounce_step(ret_cnt, !b.return_pin);
            owe_result(KIND_BUTTON, 8'h00, 1'b1, debounced_mask());
        end
        else if (b.frame_start)
        begin
            // length byte: drops any partial packet
            in_packet = 1'b0;
            rx_count  = 0;
            if (b.rx_byte < MIN_PACKET_LEN || b.rx_byte > MAX_PKT)
            begin
                owe_result(KIND_LEN, 8'h00, 1'b1, 2'b00);
                reject_results++;
            end
            else
            begin
                pkt_buf[0] = b.rx_byte;
                pkt_len    = int'(b.rx_byte);
                rx_count   = 1;
                rx_sum     = seed_reg + b.rx_byte;
                in_packet  = 1'b1;
            end
        end
        else if (in_packet && rx_count < pkt_len)
        begin
            pkt_buf[rx_count] = b.rx_byte;
            rx_count++;
            if (rx_count == pkt_len)
            begin
                in_packet = 1'b0;
                if (rx_sum != b.rx_byte)
                begin
                    owe_result(KIND_CSUM, 8'h00, 1'b1, 2'b00);
                    reject_results++;
                end
                else if (pkt_buf[1] != id_reg)
                begin
                    owe_result(KIND_ID, 8'h00, 1'b1, 2'b00);
                    reject_results++;
                end
                else
                begin
                    // button byte patched only on long packets, checksum rebuilt
                    // with the seed held now
                    if (pkt_len >= MIN_BUTTON_LEN)
                        pkt_buf[bidx_reg] = {6'b000000, debounced_mask()};
                    sum = seed_reg;
                    for (i = 0; i < pkt_len - 1; i++)
                        sum = sum + pkt_buf[i];
                    pkt_buf[pkt_len - 1] = sum;
                    for (i = 0; i < pkt_len; i++)
                        owe_result(KIND_BYTE, pkt_buf[i], (i == pkt_len - 1), 2'b00);
                    packets_relayed++;
                end
            end
            else
            begin
                rx_sum = rx_sum + b.rx_byte;
            end
        end
        // stray bytes outside a packet leave no trace
    endtask

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h000000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PACKET_ID:     id_reg    = val;
            REG_FILTER_DELAY:  delay_reg = val;
            REG_BUTTON_INDEX:  bidx_reg  = val[4:0];
            REG_CHECKSUM_SEED: seed_reg  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic reg_check(input logic [1:0] idx, input logic [7:0] want);
        logic [31:0] got;
        logic [31:0] keep;
        keep    = (idx == REG_BUTTON_INDEX) ? 32'h0000_001F : 32'h0000_00FF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if ((got & keep) !== ({24'h000000, want} & keep))
        begin
            $error("register %0d: expected %0h, got %0h", idx, want & keep, got & keep);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    task automatic send_beat(input beat_t b);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= b.req_type;
        in_ch.rx_byte     <= b.rx_byte;
        in_ch.frame_start <= b.frame_start;
        in_ch.next_pin    <= b.next_pin;
        in_ch.return_pin  <= b.return_pin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_relay(b);
        beats_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic start);
        beat_t b;
        b.req_type    = 1'b0;
        b.rx_byte     = data;
        b.frame_start = start;
        b.next_pin    = 1'($urandom_range(1, 0));
        b.return_pin  = 1'($urandom_range(1, 0));
        send_beat(b);
    endtask

    // rx_byte and frame_start are don't-care on a tick, so they get noise
    task automatic send_tick(input logic next_level, input logic return_level);
        beat_t b;
        b.req_type    = 1'b1;
        b.rx_byte     = 8'($urandom_range(255, 0));
        b.frame_start = 1'($urandom_range(1, 0));
        b.next_pin    = next_level;
        b.return_pin  = return_level;
        ticks_sent++;
        send_beat(b);
    endtask

    task automatic send_stray();
        stray_beats++;
        send_byte(8'($urandom_range(255, 0)), 1'b0);
    endtask

    // builds a packet against the current seed and identifier, optionally spoiled,
    // with ticks sprinkled between its bytes
    task automatic send_packet(input int len, input flaw_t flaw, input int tick_pct);
        logic [7:0] body [MAX_PKT];
        logic [7:0] sum;
        int         i;
        body[0] = 8'(len);
        sum     = seed_reg + body[0];
        for (i = 1; i < len - 1; i++)
        begin
            if (i == 1)
                body[i] = (flaw == FLAW_ID) ? id_reg ^ (8'h01 << $urandom_range(7, 0)) : id_reg;
            else
                body[i] = 8'($urandom_range(255, 0));
            sum = sum + body[i];
        end
        body[len - 1] = (flaw == FLAW_CSUM) ? sum + 8'($urandom_range(255, 1)) : sum;
        send_byte(body[0], 1'b1);
        for (i = 1; i < len; i++)
        begin
            if (tick_pct > 0 && $urandom_range(99, 0) < tick_pct)
                send_tick(pin_level(), pin_level());
            send_byte(body[i], 1'b0);
        end
    endtask

    // drop valid, wait for every owed beat, then let the block go quiet
    task automatic settle();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (outbound_queue.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (outbound_queue.size() != 0)
        begin
            $error("%0d result beats never arrived", outbound_queue.size());
            errors++;
            outbound_queue.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // receiver pacing: own stalls plus any requested long hold-off
    // ---------------------------------------------------------------
    initial
    begin : rx_pacing
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end
            else if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!rx_steady)
                    stall = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // result checker: every output beat against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_seen++;
            if (outbound_queue.size() == 0)
            begin
                $error("unexpected result beat: kind %0d byte %0h", out_ch.out_kind,
                       out_ch.out_byte);
                errors++;
            end
            else
            begin
                want = outbound_queue.pop_front();
                if (out_ch.out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", want.kind, out_ch.out_kind);
                    errors++;
                end
                if (out_ch.out_byte !== want.data)
                begin
                    $error("out_byte: expected %0h, got %0h", want.data, out_ch.out_byte);
                    errors++;
                end
                if (out_ch.out_last !== want.last)
                begin
                    $error("out_last: expected %0d, got %0d", want.last, out_ch.out_last);
                    errors++;
                end
                if (out_ch.button_mask !== want.mask)
                begin
                    $error("button_mask: expected %0d, got %0d", want.mask,
                           out_ch.button_mask);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset values read back, then every register written and read back
    task automatic test_register_access();
        reg_check(REG_PACKET_ID, RST_PACKET_ID);
        reg_check(REG_FILTER_DELAY, RST_FILTER_DELAY);
        reg_check(REG_BUTTON_INDEX, {3'b000, RST_BUTTON_INDEX});
        reg_check(REG_CHECKSUM_SEED, RST_CHECKSUM_SEED);
        reg_write(REG_PACKET_ID, 8'hA5);
        reg_write(REG_FILTER_DELAY, 8'd3);
        reg_write(REG_BUTTON_INDEX, 8'd17);
        reg_write(REG_CHECKSUM_SEED, 8'h9C);
        reg_check(REG_PACKET_ID, 8'hA5);
        reg_check(REG_FILTER_DELAY, 8'd3);
        reg_check(REG_BUTTON_INDEX, 8'd17);
        reg_check(REG_CHECKSUM_SEED, 8'h9C);
    endtask

    // short hand-picked sequence of the corner cases
    task automatic test_directed();
        // identifier equal to seed plus two so a two-byte packet can pass
        reg_write(REG_CHECKSUM_SEED, RST_CHECKSUM_SEED);
        reg_write(REG_PACKET_ID, RST_CHECKSUM_SEED + MIN_PACKET_LEN);
        reg_write(REG_FILTER_DELAY, 8'd0);
        // lengths out of range on both sides
        send_byte(8'd0, 1'b1);
        send_byte(8'd1, 1'b1);
        send_byte(8'd33, 1'b1);
        send_byte(8'hFF, 1'b1);
        // byte outside any packet is dropped silently
        send_stray();
        // shortest packet, checksum doubles as identifier
        send_packet(2, FLAW_NONE, 0);
        // both pressed, both released, one each
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        // wrong identifier, then wrong checksum
        send_packet(3, FLAW_ID, 0);
        send_packet(3, FLAW_CSUM, 0);
        // new length byte mid-packet restarts the gather
        send_byte(8'd6, 1'b1);
        send_byte(id_reg, 1'b0);
        send_packet(4, FLAW_NONE, 0);
        settle();
    endtask

    // checksum is checked with the seed at the length byte and rebuilt with
    // the seed held at completion
    task automatic test_seed_timing();
        logic [7:0] sum;
        reg_write(REG_PACKET_ID, 8'h5A);
        reg_write(REG_CHECKSUM_SEED, 8'h10);
        sum = 8'h10 + 8'd6 + 8'h5A + 8'h81 + 8'h7E + 8'h00;
        send_byte(8'd6, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h81, 1'b0);
        settle();
        reg_write(REG_CHECKSUM_SEED, 8'hC4);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(sum, 1'b0);
        settle();
    endtask

    // receiver holds off long while the sender keeps offering beats
    task automatic test_backpressure();
        rx_hold   = 300;
        tx_steady = 1'b1;
        send_packet(8, FLAW_NONE, 0);
        send_tick(1'b0, 1'b0);
        send_packet(15, FLAW_NONE, 10);
        send_packet(5, FLAW_CSUM, 0);
        tx_steady = 1'b0;
        settle();
    endtask

    // small filter delay: counters stop at delay plus one, a release clears one
    task automatic test_debounce_saturation();
        int n;
        reg_write(REG_FILTER_DELAY, 8'd3);
        for (n = 0; n < 8; n++)
            send_tick(1'b0, (n == 5) ? 1'b1 : 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        settle();
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 5)
            return 2;
        if (r < 55)
            return $urandom_range(10, 3);
        if (r < 90)
            return $urandom_range(24, 15);
        return $urandom_range(MAX_PKT, 25);
    endfunction

    function automatic logic [7:0] pick_bad_length();
        case ($urandom_range(2, 0))
            0: return 8'd0;
            1: return 8'd1;
            default: return 8'($urandom_range(255, MAX_PKT + 1));
        endcase
    endfunction

    // phases of random traffic, registers reprogrammed between them
    task automatic test_random_traffic();
        int phase;
        int phase_base;
        int r;
        int n;
        int len;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    reg_write(REG_PACKET_ID, 8'hFF);
                    reg_write(REG_FILTER_DELAY, 8'd0);
                    reg_write(REG_BUTTON_INDEX, 8'd2);
                    reg_write(REG_CHECKSUM_SEED, 8'h00);
                end
                1:
                begin
                    reg_write(REG_PACKET_ID, 8'h00);
                    reg_write(REG_FILTER_DELAY, 8'd254);
                    reg_write(REG_BUTTON_INDEX, 8'd30);
                    reg_write(REG_CHECKSUM_SEED, 8'hFF);
                end
                default:
                begin
                    reg_write(REG_PACKET_ID, 8'($urandom_range(255, 0)));
                    reg_write(REG_FILTER_DELAY, 8'($urandom_range(6, 0)));
                    reg_write(REG_BUTTON_INDEX, 8'($urandom_range(30, 2)));
                    reg_write(REG_CHECKSUM_SEED, 8'($urandom_range(255, 0)));
                end
            endcase
            phase_base = beats_sent - stray_beats;
            // open each of the first two phases with a patched long packet
            if (phase == 0)
            begin
                send_tick(1'b0, 1'b1);
                send_packet(MIN_BUTTON_LEN, FLAW_NONE, 0);
            end
            else if (phase == 1)
            begin
                send_packet(MAX_PKT, FLAW_NONE, 5);
            end
            while (beats_sent - stray_beats - phase_base < ITEMS_PER_PHASE)
            begin
                // occasional stretches with no idling on either side
                if ($urandom_range(9, 0) == 0)
                    tx_steady = !tx_steady;
                if ($urandom_range(9, 0) == 0)
                    rx_steady = !rx_steady;
                r = $urandom_range(99, 0);
                if (r < 50)
                begin
                    send_packet(pick_length(), FLAW_NONE, 8);
                end
                else if (r < 62)
                begin
                    n = $urandom_range(4, 1);
                    repeat (n) send_tick(pin_level(), pin_level());
                end
                else if (r < 70)
                begin
                    send_packet(pick_length(), FLAW_CSUM, 5);
                end
                else if (r < 76)
                begin
                    send_packet($urandom_range(20, 3), FLAW_ID, 5);
                end
                else if (r < 82)
                begin
                    send_byte(pick_bad_length(), 1'b1);
                end
                else if (r < 88)
                begin
                    n = $urandom_range(3, 1);
                    repeat (n) send_stray();
                end
                else if (r < 95)
                begin
                    // abandoned packet followed by a clean one
                    len = $urandom_range(MAX_PKT, 5);
                    send_byte(8'(len), 1'b1);
                    n = $urandom_range(3, 0);
                    repeat (n) send_byte(8'($urandom_range(255, 0)), 1'b0);
                    send_packet(pick_length(), FLAW_NONE, 0);
                end
                else
                begin
                    // sender waits out every owed beat
                    settle();
                end
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            settle();
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial
    begin : run
        in_ch.valid       <= 1'b0;
        in_ch.req_type    <= 1'b0;
        in_ch.rx_byte     <= 8'h00;
        in_ch.frame_start <= 1'b0;
        in_ch.next_pin    <= 1'b1;
        in_ch.return_pin  <= 1'b1;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= 4'h0;
        pwdata            <= 32'h0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed();
        test_seed_timing();
        test_backpressure();
        test_debounce_saturation();
        test_random_traffic();
        settle();

        $display("covered %0d input beats (%0d ticks, %0d stray bytes) and %0d output beats",
                 beats_sent, ticks_sent, stray_beats, results_seen);
        $display("%0d packets relayed, %0d packets or lengths rejected, filter delay 0 to 254",
                 packets_relayed, reject_results);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin : watchdog
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> panel_packet_relay_with_debounce.f
rtl/core/pprd_pkg.sv
rtl/core/pprd_if.sv
rtl/core/pprd_ram.sv
rtl/core/pprd_ctrl.sv
rtl/core/pprd_dp.sv
rtl/core/panel_packet_relay_with_debounce.sv
tb/tb.sv
